@@ rtl/mpjs_pkg.sv @@
// ----------------------------------------------------------------------------
// mpjs_pkg: shared types and constants for the job scheduler
// Table depth, field widths, operation, policy and state codes.
// ----------------------------------------------------------------------------
`default_nettype none
package mpjs_pkg;
   localparam int MaxJobs = 16;
   localparam int SlotW   = $clog2(MaxJobs);
   localparam int SumW    = 48;

   typedef enum logic [1:0] {
      OP_NEW    = 2'd0,
      OP_QUANT  = 2'd1,
      OP_FINISH = 2'd2,
      OP_NONE   = 2'd3
   } op_type;

   typedef enum logic [2:0] {
      POL_FCFS    = 3'd0,
      POL_PRIO    = 3'd1,
      POL_PPRIO   = 3'd2,
      POL_SRTF    = 3'd3,
      POL_RR      = 3'd4,
      POL_SJF     = 3'd5,
      POL_SPARE6  = 3'd6,
      POL_SPARE7  = 3'd7
   } policy_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_FIND,
      ST_UPDATE,
      ST_SCAN,
      ST_DONE
   } state_type;

   localparam logic [16:0] RemFloor = 17'h10000;   // -65536
endpackage : mpjs_pkg
`default_nettype wire

@@ rtl/multi_policy_job_scheduler_core.sv @@
// ----------------------------------------------------------------------------
// multi_policy_job_scheduler_core
// Job table with a sequencer that applies one event, then scans the table.
// ----------------------------------------------------------------------------
// Each accepted event keeps busy high through a find sweep over all MaxJobs
// slots that locates the named job and the first free slot, an update
// state, a sweep of a single shared key comparator over the updated table,
// and a result state. The result shows for one cycle on rsp_valid and
// cannot be held off by the receiver; busy stays high from accept until
// that cycle ends.
`default_nettype none
module multi_policy_job_scheduler_core (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   output logic             busy,
   input  wire logic [1:0]  req_operation,
   input  wire logic [15:0] req_job_id,
   input  wire logic        req_has_job,
   input  wire logic [31:0] req_now,
   input  wire logic [7:0]  req_job_priority,
   input  wire logic [15:0] req_run_time,
   output logic             rsp_valid,
   output logic             rsp_next_valid,
   output logic [15:0]      rsp_next_job_id,
   output logic             rsp_table_full,
   output logic [15:0]      rsp_finished_count,
   output logic signed [47:0] rsp_wait_total,
   output logic signed [47:0] rsp_response_total,
   output logic signed [47:0] rsp_turnaround_total,
   input  wire logic        psel,
   input  wire logic        penable,
   input  wire logic        pwrite,
   input  wire logic [1:0]  paddr,
   input  wire logic [31:0] pwdata,
   output logic [31:0]      prdata,
   output logic             pready
);
   import mpjs_pkg::*;

   // table storage (valid/started in flops cleared by reset)
   logic [MaxJobs-1:0] valid_ff, valid_in, started_ff, started_in;
   logic [15:0] id_ff       [MaxJobs];
   logic [31:0] arrival_ff  [MaxJobs];
   logic [16:0] remain_ff   [MaxJobs];
   logic [15:0] required_ff [MaxJobs];
   logic [7:0]  prio_ff     [MaxJobs];
   logic [32:0] lastrun_ff  [MaxJobs];
   logic [32:0] first_ff    [MaxJobs];
   logic [15:0] order_ff    [MaxJobs];

   logic [15:0] ins_cnt_ff, ins_cnt_in, done_ff, done_in;
   logic [SumW-1:0] wsum_ff, wsum_in, rsum_ff, rsum_in, tsum_ff, tsum_in;
   logic [2:0] policy_ff, policy_in;

   state_type state_ff, state_in;
   logic [SlotW-1:0] idx_ff, idx_in;

   // latched event
   op_type      op_ff;
   logic [15:0] jid_ff;
   logic        has_ff;
   logic [31:0] now_ff;
   logic [7:0]  pri_ff;
   logic [15:0] rt_ff;

   // find results
   logic             hit_ff, hit_in, free_ok_ff, free_ok_in;
   logic [SlotW-1:0] hit_idx_ff, hit_idx_in, free_idx_ff, free_idx_in;
   // scan results
   logic             best_ok_ff, best_ok_in;
   logic [SlotW-1:0] best_idx_ff, best_idx_in;
   logic             full_ff, full_in, named_ff, named_in;

   logic accept, cfg_wr, last_idx;
   logic preempt;

   assign accept   = start && !busy;
   assign cfg_wr   = psel && penable && pwrite && pready;
   assign pready   = 1'b1;
   assign last_idx = (idx_ff == SlotW'(MaxJobs - 1));
   assign preempt  = (policy_ff == POL_PPRIO) || (policy_ff == POL_SRTF) ||
                     (policy_ff == POL_RR);

   always_comb begin
      prdata = '0;
      if (paddr == 2'd0) begin
         prdata = {29'd0, policy_ff};
      end
   end

   assign policy_in = (cfg_wr && paddr == 2'd0) ? pwdata[2:0] : policy_ff;

   // shared comparator: is slot idx better than current best?
   function automatic logic [33:0] key_of(input logic [2:0] pol, input logic [7:0] p,
                                          input logic [16:0] rm, input logic [32:0] lr,
                                          input logic [15:0] rq);
      logic [33:0] k;
      k = '0;
      unique case (pol)
         POL_PRIO, POL_PPRIO: k = {26'd0, p} ^ 34'h200000000;
         POL_SRTF:            k = {{17{rm[16]}}, rm} ^ 34'h200000000;
         POL_RR:              k = {lr[32], lr} ^ 34'h200000000;
         POL_SJF:             k = {18'd0, rq} ^ 34'h200000000;
         default:             k = '0;
      endcase
      return k;
   endfunction

   logic [33:0] key_a, key_b;
   logic        better;
   always_comb begin
      key_a = key_of(policy_ff, prio_ff[idx_ff], remain_ff[idx_ff],
                     lastrun_ff[idx_ff], required_ff[idx_ff]);
      key_b = key_of(policy_ff, prio_ff[best_idx_ff], remain_ff[best_idx_ff],
                     lastrun_ff[best_idx_ff], required_ff[best_idx_ff]);
      if (key_a != key_b) begin
         better = key_a < key_b;
      end else if (arrival_ff[idx_ff] != arrival_ff[best_idx_ff]) begin
         better = arrival_ff[idx_ff] < arrival_ff[best_idx_ff];
      end else begin
         better = order_ff[idx_ff] < order_ff[best_idx_ff];
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:   if (accept) state_in = ST_FIND;
         ST_FIND:   if (last_idx) state_in = ST_UPDATE;
         ST_UPDATE: state_in = ST_SCAN;
         ST_SCAN:   if (last_idx) state_in = ST_DONE;
         ST_DONE:   state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   // sequencer datapath
   logic do_new, do_quant, do_fin;
   logic [31:0] h_arr;
   logic [SumW-1:0] w_val, r_val, t_val;
   always_comb begin
      idx_in      = idx_ff;
      hit_in      = hit_ff;
      hit_idx_in  = hit_idx_ff;
      free_ok_in  = free_ok_ff;
      free_idx_in = free_idx_ff;
      best_ok_in  = best_ok_ff;
      best_idx_in = best_idx_ff;
      full_in     = full_ff;
      named_in    = named_ff;
      valid_in    = valid_ff;
      started_in  = started_ff;
      ins_cnt_in  = ins_cnt_ff;
      done_in     = done_ff;
      wsum_in     = wsum_ff;
      rsum_in     = rsum_ff;
      tsum_in     = tsum_ff;
      do_new      = 1'b0;
      do_quant    = 1'b0;
      do_fin      = 1'b0;
      h_arr       = arrival_ff[hit_idx_ff];
      t_val       = SumW'({1'b0, now_ff}) - SumW'({1'b0, h_arr});
      w_val       = t_val - SumW'(required_ff[hit_idx_ff]);
      r_val       = SumW'(signed'(first_ff[hit_idx_ff])) - SumW'({1'b0, h_arr});
      unique case (state_ff)
         ST_IDLE: begin
            idx_in     = '0;
            hit_in     = 1'b0;
            free_ok_in = 1'b0;
         end
         ST_FIND: begin
            if (!hit_in && valid_ff[idx_ff] && id_ff[idx_ff] == jid_ff) begin
               hit_in     = 1'b1;
               hit_idx_in = idx_ff;
            end
            if (!free_ok_in && !valid_ff[idx_ff]) begin
               free_ok_in  = 1'b1;
               free_idx_in = idx_ff;
            end
            idx_in = idx_ff + 1'b1;
         end
         ST_UPDATE: begin
            full_in    = 1'b0;
            named_in   = 1'b0;
            best_ok_in = 1'b0;
            idx_in     = '0;
            unique case (op_ff)
               OP_NEW: begin
                  if (free_ok_ff) begin
                     do_new = 1'b1;
                     valid_in[free_idx_ff]   = 1'b1;
                     started_in[free_idx_ff] = 1'b0;
                     ins_cnt_in = ins_cnt_ff + 1'b1;
                  end else begin
                     full_in = 1'b1;
                  end
               end
               OP_QUANT: begin
                  if (has_ff && hit_ff) begin
                     do_quant = 1'b1;
                     started_in[hit_idx_ff] = 1'b1;
                     if (preempt) begin
                        ins_cnt_in = ins_cnt_ff + 1'b1;
                     end else begin
                        named_in    = 1'b1;
                        best_idx_in = hit_idx_ff;
                     end
                  end
               end
               OP_FINISH: begin
                  if (hit_ff) begin
                     do_fin = 1'b1;
                     if (done_ff != 16'hFFFF) done_in = done_ff + 1'b1;
                     wsum_in = wsum_ff + w_val;
                     rsum_in = rsum_ff + r_val;
                     tsum_in = tsum_ff + t_val;
                     valid_in[hit_idx_ff]   = 1'b0;
                     started_in[hit_idx_ff] = 1'b0;
                  end
               end
               default: ;
            endcase
         end
         ST_SCAN: begin
            if (!named_ff && valid_ff[idx_ff] && (!best_ok_ff || better)) begin
               best_ok_in  = 1'b1;
               best_idx_in = idx_ff;
            end
            idx_in = idx_ff + 1'b1;
         end
         ST_DONE: ;
         default: ;
      endcase
   end

   // outputs
   always_comb begin
      busy                 = (state_ff != ST_IDLE);
      rsp_valid            = (state_ff == ST_DONE);
      rsp_next_valid       = named_ff || best_ok_ff;
      rsp_next_job_id      = rsp_next_valid ? id_ff[best_idx_ff] : 16'd0;
      rsp_table_full       = full_ff;
      rsp_finished_count   = done_ff;
      rsp_wait_total       = signed'(wsum_ff);
      rsp_response_total   = signed'(rsum_ff);
      rsp_turnaround_total = signed'(tsum_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         valid_ff   <= '0;
         started_ff <= '0;
         ins_cnt_ff <= '0;
         done_ff    <= '0;
         wsum_ff    <= '0;
         rsum_ff    <= '0;
         tsum_ff    <= '0;
         policy_ff  <= '0;
         named_ff   <= 1'b0;
         best_ok_ff <= 1'b0;
         full_ff    <= 1'b0;
      end else begin
         state_ff   <= state_in;
         valid_ff   <= valid_in;
         started_ff <= started_in;
         ins_cnt_ff <= ins_cnt_in;
         done_ff    <= done_in;
         wsum_ff    <= wsum_in;
         rsum_ff    <= rsum_in;
         tsum_ff    <= tsum_in;
         policy_ff  <= policy_in;
         named_ff   <= named_in;
         best_ok_ff <= best_ok_in;
         full_ff    <= full_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff      <= idx_in;
      hit_ff      <= hit_in;
      hit_idx_ff  <= hit_idx_in;
      free_ok_ff  <= free_ok_in;
      free_idx_ff <= free_idx_in;
      best_idx_ff <= best_idx_in;
      if (accept) begin
         op_ff  <= op_type'(req_operation);
         jid_ff <= req_job_id;
         has_ff <= req_has_job;
         now_ff <= req_now;
         pri_ff <= req_job_priority;
         rt_ff  <= req_run_time;
      end
      if (do_new) begin
         id_ff[free_idx_ff]       <= jid_ff;
         arrival_ff[free_idx_ff]  <= now_ff;
         remain_ff[free_idx_ff]   <= {1'b0, rt_ff};
         required_ff[free_idx_ff] <= rt_ff;
         prio_ff[free_idx_ff]     <= pri_ff;
         lastrun_ff[free_idx_ff]  <= '1;
         first_ff[free_idx_ff]    <= '1;
         order_ff[free_idx_ff]    <= ins_cnt_ff;
      end
      if (do_quant) begin
         lastrun_ff[hit_idx_ff] <= {1'b0, now_ff};
         if (remain_ff[hit_idx_ff] != RemFloor) begin
            remain_ff[hit_idx_ff] <= remain_ff[hit_idx_ff] - 17'd1;
         end
         if (!started_ff[hit_idx_ff]) begin
            first_ff[hit_idx_ff] <= {1'b0, now_ff} - 33'd1;
         end
         if (preempt) order_ff[hit_idx_ff] <= ins_cnt_ff;
      end
   end
endmodule : multi_policy_job_scheduler_core
`default_nettype wire

@@ rtl/mpjs_checker.sv @@
// ----------------------------------------------------------------------------
// mpjs_checker: port-level checks for the job scheduler
// Watches the command handshake and the result strobe.
// ----------------------------------------------------------------------------
`default_nettype none
module mpjs_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        start,
   input wire logic        busy,
   input wire logic        rsp_valid,
   input wire logic        rsp_next_valid,
   input wire logic [15:0] rsp_next_job_id,
   input wire logic [15:0] rsp_finished_count
);
   // a result ends the busy period
   a_rsp_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> busy) else $error("result beat outside busy");
   a_rsp_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !busy) else $error("busy after result beat");
   a_accept: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy && !rsp_valid) else $error("accept not taken");
   a_novalid_id: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_next_valid) |-> rsp_next_job_id == 16'd0)
      else $error("stale job id");
   a_count: assert property (@(posedge clock) disable iff (reset)
      !busy && !$past(busy) |-> $stable(rsp_finished_count))
      else $error("count moved while idle");
endmodule : mpjs_checker

bind multi_policy_job_scheduler_core mpjs_checker u_mpjs_checker (
   .clock(clock), .reset(reset), .start(start), .busy(busy),
   .rsp_valid(rsp_valid), .rsp_next_valid(rsp_next_valid),
   .rsp_next_job_id(rsp_next_job_id), .rsp_finished_count(rsp_finished_count)
);
`default_nettype wire
